@@ rtl/tfpl_pkg.sv @@
// ============================================================================
// tfpl_pkg - shared types and constants for the thermal flow PI loop
// Sequencer states, register indexes, fixed arithmetic constants and the
// power-to-flow table.
// ============================================================================
package tfpl_pkg;

   localparam int TFPL_TABLE_POINTS = 11;
   localparam int TFPL_PWM_WIDTH    = 10;
   localparam int TABLE_CAP         = 32;

   // register indexes on the configuration port
   localparam logic [2:0] CSR_DELTA_T   = 3'd0;
   localparam logic [2:0] CSR_KP_GAIN   = 3'd1;
   localparam logic [2:0] CSR_KI_GAIN   = 3'd2;
   localparam logic [2:0] CSR_AIR_THR   = 3'd3;
   localparam logic [2:0] CSR_FLOW_THR  = 3'd4;

   localparam logic [12:0] DELTA_T_RESET  = 13'd1000;
   localparam logic [15:0] KP_RESET       = 16'd1966;
   localparam logic [15:0] KI_RESET       = 16'd393;
   localparam logic [16:0] AIR_THR_RESET  = 17'd521;
   localparam logic [16:0] FLOW_THR_RESET = 17'd4297;

   localparam logic [27:0] PERCENT_DIV = 28'd100;
   localparam logic [27:0] INTEG_DIV   = 28'd100000;
   // 65536 * heater resistance in milliohm
   localparam logic [27:0] POWER_DIV   = 28'd235929600;
   localparam logic [16:0] POWER_MAX   = 17'd80000;
   localparam logic [16:0] DUTY_FULL   = 17'd65536;

   localparam logic [1:0] CLASS_AIR   = 2'd0;
   localparam logic [1:0] CLASS_STILL = 2'd1;
   localparam logic [1:0] CLASS_FLOW  = 2'd2;
   localparam logic [9:0] ALARM_AIR_MS   = 10'd500;
   localparam logic [9:0] ALARM_STILL_MS = 10'd1000;
   localparam logic [9:0] ALARM_OFF_MS   = 10'd0;

   localparam logic [16:0] TAB_MW [TABLE_CAP] = '{
      17'd1004,  17'd6695,  17'd9649,  17'd12013, 17'd14074, 17'd15943,
      17'd17676, 17'd19306, 17'd20856, 17'd22341, 17'd23772, 17'd0,
      17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
      17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
      17'd0, 17'd0, 17'd0, 17'd0};

   localparam logic [12:0] TAB_FLOW [TABLE_CAP] = '{
      13'd0,    13'd510,  13'd1021, 13'd1531, 13'd2041, 13'd2552,
      13'd3062, 13'd3572, 13'd4083, 13'd4593, 13'd5104, 13'd0,
      13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
      13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
      13'd0, 13'd0, 13'd0, 13'd0};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KP_MUL,
      ST_KP_DIV,
      ST_KI_MUL,
      ST_DU_MUL,
      ST_NUM_MUL,
      ST_NUM_DIV,
      ST_PW_MUL1,
      ST_PW_MUL2,
      ST_PW_DIV,
      ST_PWM_MUL,
      ST_SCAN,
      ST_FL_MUL,
      ST_FL_DIV,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/thermal_flow_pi_loop.sv @@
// ============================================================================
// thermal_flow_pi_loop - PI heater loop of a thermal flow probe
// PI duty with back-calculation anti-windup, heater power, flow class and
// table-interpolated flow, computed with a bit-serial multiplier and divider.
// ============================================================================
// Usage:
//   req channel: one control tick per transaction (temperatures, bus voltage,
//   elapsed time). rsp channel: one result per tick (PWM code, duty, power,
//   flow class, alarm half period, flow). csr channel: register writes, always
//   ready; write only while no tick is in flight.
//   Every product goes through a shift-and-add multiplier one multiplier
//   bit per cycle, every quotient through a restoring divider one quotient
//   bit per cycle (34, 60, 45 and 32 bits), and the table segment is
//   searched one point per cycle.
//   One tick is worked on at a time; the next tick can be accepted as soon
//   as the previous result sits in the output register, even if it is not
//   yet taken. If rsp_tready stays low, the finished result of the next tick
//   waits in the sequencer until the output register is free. Reset loads
//   the register defaults, clears the integral and empties the output
//   register.
// ============================================================================
module thermal_flow_pi_loop
   import tfpl_pkg::*;
#(
   parameter int TABLE_POINTS = TFPL_TABLE_POINTS,
   parameter int PWM_WIDTH    = TFPL_PWM_WIDTH,
   localparam int RSP_BITS    = PWM_WIDTH + 58,
   localparam int RSP_W       = ((RSP_BITS + 7) / 8) * 8,
   localparam int SEG_W       = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS - 1) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // upstream_temp_centi[14:0], heated_temp_centi[29:15], bus_mv[43:30],
   // dt_ms[59:44], zero fill
   input  logic [63:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // pwm_code, duty_q16, power_mw, flow_class, alarm_half_period_ms,
   // flow_centi_lpm, zero fill
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [16:0]       csr_wdata
);

   localparam logic [15:0] PMAX = 16'((17'd1 << PWM_WIDTH) - 17'd1);

   state_type state_ff, state_in;

   logic [12:0] delta_ff;
   logic [15:0] kp_ff, ki_ff;
   logic [16:0] air_thr_ff, flow_thr_ff;

   logic signed [17:0] err_ff, err_in;
   logic [13:0]        mv_ff, mv_in;
   logic [15:0]        dt_ff, dt_in;
   logic               sgn_ff, sgn_in;
   logic [63:0]        mul_a_ff, mul_a_in;
   logic [15:0]        mul_b_ff, mul_b_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        dvd_ff, dvd_in;
   logic [27:0]        dvs_ff, dvs_in;
   logic [27:0]        rem_ff, rem_in;
   logic [63:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [35:0] u_ff, u_in;
   logic [16:0]        duty_ff, duty_in;
   logic signed [47:0] kiterm_ff, kiterm_in;
   logic [16:0]        power_ff, power_in;
   logic [PWM_WIDTH-1:0] pwm_ff, pwm_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [12:0]        flow_ff, flow_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // serial datapath helpers
   logic        mul_busy;
   logic [63:0] mul_acc_step;
   logic [28:0] trial;
   logic        ge;
   logic [27:0] rem_step;
   logic [63:0] q_fin;
   logic        div_last;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mul_busy     = (mul_b_ff != 16'd0);
   assign mul_acc_step = acc_ff + (mul_b_ff[0] ? mul_a_ff : 64'd0);
   assign trial        = {rem_ff, dvd_ff[cnt_ff]};
   assign ge           = (trial >= {1'b0, dvs_ff});
   assign rem_step     = ge ? 28'(trial - {1'b0, dvs_ff}) : trial[27:0];
   assign q_fin        = {quo_ff[62:0], ge};
   assign div_last     = (cnt_ff == 6'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff    <= DELTA_T_RESET;
         kp_ff       <= KP_RESET;
         ki_ff       <= KI_RESET;
         air_thr_ff  <= AIR_THR_RESET;
         flow_thr_ff <= FLOW_THR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DELTA_T:  delta_ff    <= csr_wdata[12:0];
            CSR_KP_GAIN:  kp_ff       <= csr_wdata[15:0];
            CSR_KI_GAIN:  ki_ff       <= csr_wdata[15:0];
            CSR_AIR_THR:  air_thr_ff  <= csr_wdata;
            CSR_FLOW_THR: flow_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      mv_ff       <= mv_in;
      dt_ff       <= dt_in;
      sgn_ff      <= sgn_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      acc_ff      <= acc_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      u_ff        <= u_in;
      duty_ff     <= duty_in;
      kiterm_ff   <= kiterm_in;
      power_ff    <= power_in;
      pwm_ff      <= pwm_in;
      seg_ff      <= seg_in;
      flow_ff     <= flow_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      logic signed [17:0] up_s, hot_s, err_new;
      logic [17:0]        err_mag;
      logic signed [35:0] t1, u_new;
      logic [16:0]        duty_new;
      logic signed [36:0] du;
      logic signed [47:0] prod_s, num, qs;
      logic signed [48:0] integ_sum;
      logic [16:0]        pw_new;
      logic [4:0]         i0, i1;
      logic [12:0]        flow_sum;
      logic [1:0]         cls;
      logic [9:0]         alarm;
      logic [15:0]        duty_out;

      state_in     = state_ff;
      err_in       = err_ff;
      mv_in        = mv_ff;
      dt_in        = dt_ff;
      sgn_in       = sgn_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      acc_in       = acc_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      integ_in     = integ_ff;
      u_in         = u_ff;
      duty_in      = duty_ff;
      kiterm_in    = kiterm_ff;
      power_in     = power_ff;
      pwm_in       = pwm_ff;
      seg_in       = seg_ff;
      flow_in      = flow_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      up_s    = 18'(signed'(req_tdata[14:0]));
      hot_s   = 18'(signed'(req_tdata[29:15]));
      err_new = up_s + signed'({5'd0, delta_ff}) - hot_s;
      err_mag = err_ff[17] ? 18'(-err_ff) : 18'(err_ff);

      t1       = sgn_ff ? -36'(signed'({1'b0, q_fin[34:0]}))
                        : 36'(signed'({1'b0, q_fin[34:0]}));
      u_new    = t1 + 36'(integ_ff);
      duty_new = u_new < 0 ? 17'd0
               : (u_new > signed'(36'(DUTY_FULL)) ? DUTY_FULL : u_new[16:0]);
      du       = signed'(37'(duty_ff)) - 37'(u_ff);
      prod_s   = sgn_ff ? -signed'(acc_ff[47:0]) : signed'(acc_ff[47:0]);
      num      = kiterm_ff + prod_s;
      qs       = sgn_ff ? -signed'(q_fin[47:0]) : signed'(q_fin[47:0]);
      integ_sum = 49'(integ_ff) + 49'(qs);
      pw_new   = (q_fin > 64'(POWER_MAX)) ? POWER_MAX : q_fin[16:0];

      i0       = 5'(seg_ff);
      i1       = 5'(seg_ff) + 5'd1;
      flow_sum = TAB_FLOW[i0] + q_fin[12:0];

      if (power_ff < air_thr_ff) begin
         cls = CLASS_AIR;
         alarm = ALARM_AIR_MS;
      end else if (power_ff > flow_thr_ff) begin
         cls = CLASS_FLOW;
         alarm = ALARM_OFF_MS;
      end else begin
         cls = CLASS_STILL;
         alarm = ALARM_STILL_MS;
      end
      duty_out = duty_ff[16] ? 16'hFFFF : duty_ff[15:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               err_in   = err_new;
               mv_in    = req_tdata[43:30];
               dt_in    = req_tdata[59:44];
               sgn_in   = err_new[17];
               mul_a_in = 64'(err_new[17] ? 18'(-err_new) : 18'(err_new));
               mul_b_in = kp_ff;
               acc_in   = '0;
               state_in = ST_KP_MUL;
            end
         end
         ST_KP_MUL, ST_KI_MUL, ST_DU_MUL, ST_NUM_MUL, ST_PW_MUL1, ST_PW_MUL2,
         ST_PWM_MUL, ST_FL_MUL: begin
            if (mul_busy) begin
               acc_in   = mul_acc_step;
               mul_a_in = {mul_a_ff[62:0], 1'b0};
               mul_b_in = {1'b0, mul_b_ff[15:1]};
            end else begin
               // product ready: set up the next operation
               dvd_in = acc_ff;
               rem_in = '0;
               quo_in = '0;
               acc_in = '0;
               unique case (state_ff)
                  ST_KP_MUL: begin
                     dvs_in   = PERCENT_DIV;
                     cnt_in   = 6'd33;
                     state_in = ST_KP_DIV;
                  end
                  ST_KI_MUL: begin
                     kiterm_in = prod_s;
                     sgn_in    = du[36];
                     mul_a_in  = 64'(du[36] ? 37'(-du) : 37'(du));
                     mul_b_in  = 16'(PERCENT_DIV);
                     state_in  = ST_DU_MUL;
                  end
                  ST_DU_MUL: begin
                     sgn_in   = num[47];
                     mul_a_in = 64'(num[47] ? 48'(-num) : 48'(num));
                     mul_b_in = dt_ff;
                     state_in = ST_NUM_MUL;
                  end
                  ST_NUM_MUL: begin
                     dvs_in   = INTEG_DIV;
                     cnt_in   = 6'd59;
                     state_in = ST_NUM_DIV;
                  end
                  ST_PW_MUL1: begin
                     mul_a_in = acc_ff;
                     mul_b_in = 16'(mv_ff);
                     state_in = ST_PW_MUL2;
                  end
                  ST_PW_MUL2: begin
                     dvs_in   = POWER_DIV;
                     cnt_in   = 6'd44;
                     state_in = ST_PW_DIV;
                  end
                  ST_PWM_MUL: begin
                     pwm_in   = acc_ff[16 +: PWM_WIDTH];
                     seg_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     dvs_in   = 28'(TAB_MW[i1] - TAB_MW[i0]);
                     cnt_in   = 6'd31;
                     state_in = ST_FL_DIV;
                  end
               endcase
            end
         end
         ST_KP_DIV, ST_NUM_DIV, ST_PW_DIV, ST_FL_DIV: begin
            rem_in = rem_step;
            quo_in = q_fin;
            cnt_in = cnt_ff - 6'd1;
            if (div_last) begin
               acc_in = '0;
               unique case (state_ff)
                  ST_KP_DIV: begin
                     u_in     = u_new;
                     duty_in  = duty_new;
                     sgn_in   = err_ff[17];
                     mul_a_in = 64'(err_mag);
                     mul_b_in = ki_ff;
                     state_in = ST_KI_MUL;
                  end
                  ST_NUM_DIV: begin
                     // saturate the integral at the 32-bit limits
                     if (integ_sum > 49'sh0_7FFF_FFFF)
                        integ_in = 32'sh7FFF_FFFF;
                     else if (integ_sum < -49'sh0_8000_0000)
                        integ_in = 32'sh8000_0000;
                     else
                        integ_in = integ_sum[31:0];
                     mul_a_in = 64'(duty_ff);
                     mul_b_in = 16'(mv_ff);
                     state_in = ST_PW_MUL1;
                  end
                  ST_PW_DIV: begin
                     power_in = pw_new;
                     mul_a_in = 64'(duty_ff);
                     mul_b_in = PMAX;
                     state_in = ST_PWM_MUL;
                  end
                  default: begin
                     flow_in  = flow_sum;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            priority if (power_ff <= TAB_MW[0]) begin
               flow_in  = '0;
               state_in = ST_FINISH;
            end else if (power_ff >= TAB_MW[i0] && power_ff <= TAB_MW[i1]) begin
               if (TAB_MW[i1] == TAB_MW[i0]) begin
                  flow_in  = TAB_FLOW[i0];
                  state_in = ST_FINISH;
               end else begin
                  mul_a_in = 64'(power_ff - TAB_MW[i0]);
                  mul_b_in = 16'(TAB_FLOW[i1] - TAB_FLOW[i0]);
                  acc_in   = '0;
                  state_in = ST_FL_MUL;
               end
            end else if (32'(seg_ff) == TABLE_POINTS - 2) begin
               flow_in  = TAB_FLOW[5'(TABLE_POINTS - 1)];
               state_in = ST_FINISH;
            end else begin
               seg_in = seg_ff + SEG_W'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({flow_ff, alarm, cls, power_ff, duty_out,
                                      pwm_ff});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
